// File: hw/rtl/e2q_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Euler-to-quaternion package
// Constants, the arctangent table and the fixed-point helpers that the
// angle units and the top level share.
// ----------------------------------------------------------------------------
package e2q_pkg;

    // Angle units: the raw input is the half angle in 2^-17 degree steps.
    localparam logic signed [33:0] HALF_TURN    = 34'sd23592960;
    localparam logic signed [26:0] QUARTER_TURN = 27'sd11796480;
    localparam logic [55:0]        HALF_TURN_RND = 56'd11796480;

    // Pi in Q2.30 and the reciprocal of 45 used for the radian conversion.
    localparam logic [31:0] PI_Q30    = 32'hC90FDAA2;
    localparam logic [31:0] RECIP45   = 32'd3054198966;
    localparam logic [23:0] RECIP45_S = 24'd1456;

    // CORDIC start value (inverse gain for 32 steps) and unity in Q2.30.
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam int unsigned        MAX_ITER    = 32;

    // Arctangent of 2^-i in Q2.30 radians.
    localparam logic signed [31:0] ATAN_TAB [0:31] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
        32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
    };

    // Rounded Q2.30 product: floor((a*b + 2^29) / 2^30).
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return p[61:30];
    endfunction

    // Clamp a sum to the range from -1 to 1 in Q2.30.
    function automatic logic signed [31:0] sat_q30(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v > 33'(ONE_Q30)) begin
            res = ONE_Q30;
        end else if (v < -33'(ONE_Q30)) begin
            res = -ONE_Q30;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/e2q_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Euler-to-quaternion stream interfaces
// Valid/ready channels for the angle words and the quaternion words.
// ----------------------------------------------------------------------------
interface e2q_angle_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
    logic signed [31:0] roll_deg;

    modport source(output valid, output pitch_deg, output yaw_deg, output roll_deg,
                   input ready);
    modport sink(input valid, input pitch_deg, input yaw_deg, input roll_deg,
                 output ready);
endinterface

interface e2q_quat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;

    modport source(output valid, output quat_x, output quat_y, output quat_z,
                   output quat_w, input ready);
    modport sink(input valid, input quat_x, input quat_y, input quat_z,
                 input quat_w, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/e2q_half_sincos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Half-angle sine and cosine
// Reduces one half angle to a period, folds it to a quarter turn, converts it
// to radians and runs a pipelined CORDIC; 5 + iteration count stages.
// ----------------------------------------------------------------------------
module e2q_half_sincos #(
    parameter int unsigned N_ITER = 24
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_angle,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    import e2q_pkg::*;

    // Stage 1: split the shifted angle into turns of 2^20 and a remainder.
    logic signed [33:0] s1_sum;
    logic signed [13:0] s1_turn;
    logic [12:0]        s1_u;
    logic [23:0]        s1_prod;
    logic [12:0]        r_s1_u;
    logic [6:0]         r_s1_q;
    logic [19:0]        r_s1_lo;

    assign s1_sum  = 34'(i_angle) + HALF_TURN;
    assign s1_turn = s1_sum[33:20];
    assign s1_u    = 13'(s1_turn + 14'sd2048);
    assign s1_prod = 24'(s1_u) * RECIP45_S;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_u  <= s1_u;
            r_s1_q  <= s1_prod[22:16];
            r_s1_lo <= s1_sum[19:0];
        end
    end

    // Stage 2: finish the modulo by 45, recentre and fold to a quarter turn.
    logic [12:0]        s2_q45;
    logic [12:0]        s2_rem;
    logic [5:0]         s2_m;
    logic [5:0]         s2_m2;
    logic signed [26:0] s2_r;
    logic signed [26:0] s2_f;
    logic               s2_neg;
    logic [26:0]        s2_abs;
    logic [23:0]        r_s2_mag;
    logic               r_s2_sgn;
    logic               r_s2_neg;

    always_comb begin
        s2_q45 = 13'(r_s1_q) * 13'd45;
        s2_rem = r_s1_u - s2_q45;
        s2_m   = (s2_rem >= 13'd45) ? 6'(s2_rem - 13'd45) : 6'(s2_rem);
        s2_m2  = (s2_m >= 6'd23) ? (s2_m - 6'd23) : (s2_m + 6'd22);
        s2_r   = $signed({1'b0, s2_m2, r_s1_lo}) - 27'(HALF_TURN);
        s2_neg = 1'b0;
        s2_f   = s2_r;
        if (s2_r > QUARTER_TURN) begin
            s2_f   = s2_r - 27'(HALF_TURN);
            s2_neg = 1'b1;
        end else if (s2_r < -QUARTER_TURN) begin
            s2_f   = s2_r + 27'(HALF_TURN);
            s2_neg = 1'b1;
        end
        s2_abs = s2_f[26] ? 27'(-s2_f) : 27'(s2_f);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_mag <= s2_abs[23:0];
            r_s2_sgn <= s2_f[26];
            r_s2_neg <= s2_neg;
        end
    end

    // Stage 3: scale by pi with rounding; the division by 2^19 is a shift.
    logic [55:0] s3_a;
    logic [36:0] r_s3_b;
    logic        r_s3_sgn;
    logic        r_s3_neg;

    assign s3_a = 56'(r_s2_mag) * 56'(PI_Q30) + HALF_TURN_RND;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_b   <= s3_a[55:19];
            r_s3_sgn <= r_s2_sgn;
            r_s3_neg <= r_s2_neg;
        end
    end

    // Stage 4: estimate the quotient by 45 with a reciprocal multiply.
    logic [63:0] s4_p;
    logic [31:0] r_s4_q;
    logic [7:0]  r_s4_lo;
    logic        r_s4_sgn;
    logic        r_s4_neg;

    assign s4_p = 64'(r_s3_b[36:5]) * 64'(RECIP45);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_q   <= s4_p[63:32];
            r_s4_lo  <= r_s3_b[7:0];
            r_s4_sgn <= r_s3_sgn;
            r_s4_neg <= r_s3_neg;
        end
    end

    // Stage 5: the estimate is low by at most three; fix it and apply the sign.
    logic [7:0]         s5_q45;
    logic [7:0]         s5_rem;
    logic [1:0]         s5_corr;
    logic [31:0]        s5_mag;
    logic signed [31:0] r_s5_z;
    logic               r_s5_neg;

    always_comb begin
        s5_q45 = r_s4_q[7:0] * 8'd45;
        s5_rem = r_s4_lo - s5_q45;
        if (s5_rem >= 8'd135) begin
            s5_corr = 2'd3;
        end else if (s5_rem >= 8'd90) begin
            s5_corr = 2'd2;
        end else if (s5_rem >= 8'd45) begin
            s5_corr = 2'd1;
        end else begin
            s5_corr = 2'd0;
        end
        s5_mag = r_s4_q + 32'(s5_corr);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5_z   <= r_s4_sgn ? $signed(-s5_mag) : $signed(s5_mag);
            r_s5_neg <= r_s4_neg;
        end
    end

    // CORDIC rotation: one registered micro-rotation per stage.
    localparam int unsigned NS = (N_ITER > MAX_ITER) ? MAX_ITER : N_ITER;

    logic signed [31:0] r_cx [0:NS-1];
    logic signed [31:0] r_cy [0:NS-1];
    logic signed [31:0] r_cz [0:NS-1];
    logic               r_cneg [0:NS-1];

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_rot
            logic signed [31:0] px;
            logic signed [31:0] py;
            logic signed [31:0] pz;
            logic               pneg;

            if (gi == 0) begin : g_first
                assign px   = CORDIC_GAIN;
                assign py   = '0;
                assign pz   = r_s5_z;
                assign pneg = r_s5_neg;
            end else begin : g_next
                assign px   = r_cx[gi-1];
                assign py   = r_cy[gi-1];
                assign pz   = r_cz[gi-1];
                assign pneg = r_cneg[gi-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (pz >= 0) begin
                        r_cx[gi] <= px - (py >>> gi);
                        r_cy[gi] <= py + (px >>> gi);
                        r_cz[gi] <= pz - ATAN_TAB[gi];
                    end else begin
                        r_cx[gi] <= px + (py >>> gi);
                        r_cy[gi] <= py - (px >>> gi);
                        r_cz[gi] <= pz + ATAN_TAB[gi];
                    end
                    r_cneg[gi] <= pneg;
                end
            end
        end
    endgenerate

    // Undo the quarter-turn fold by negating both results.
    assign o_cos = r_cneg[NS-1] ? -r_cx[NS-1] : r_cx[NS-1];
    assign o_sin = r_cneg[NS-1] ? -r_cy[NS-1] : r_cy[NS-1];

endmodule
`default_nettype wire

// File: hw/rtl/euler_to_quaternion.sv
`default_nettype none
// An accepted angle word passes the half-angle stages, the CORDIC chain (CORDIC_ITERATIONS
// over 32 counts as 32) and the product stages, all fully pipelined, to the output word.
// Throughput: one word per cycle while the output is not held.
// A stall on the output freezes every stage in place.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// Euler angles to quaternion
// Takes pitch, yaw and roll in Q16.16 degrees and returns the unit quaternion
// in Q2.30, rounded and clamped to the range from -1 to 1.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
    parameter int unsigned CORDIC_ITERATIONS = 24
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    e2q_angle_if.sink  i_angles,
    e2q_quat_if.source o_quat
);
    import e2q_pkg::*;

    localparam int unsigned NS  = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER
                                                                  : CORDIC_ITERATIONS;
    localparam int unsigned LAT = NS + 8;

    // Pipeline advance: every stage moves unless the output word is held.
    logic            pipe_en;
    logic [LAT-1:0]  r_vld;

    assign pipe_en        = !r_vld[LAT-1] || o_quat.ready;
    assign i_angles.ready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[LAT-2:0], i_angles.valid};
        end
    end

    // Sine and cosine of the three half angles.
    logic signed [31:0] sp, cp, sy, cy, sr, cr;

    e2q_half_sincos #(.N_ITER(NS)) u_pitch (
        .i_clk(i_clk), .i_en(pipe_en), .i_angle(i_angles.pitch_deg),
        .o_sin(sp), .o_cos(cp)
    );
    e2q_half_sincos #(.N_ITER(NS)) u_yaw (
        .i_clk(i_clk), .i_en(pipe_en), .i_angle(i_angles.yaw_deg),
        .o_sin(sy), .o_cos(cy)
    );
    e2q_half_sincos #(.N_ITER(NS)) u_roll (
        .i_clk(i_clk), .i_en(pipe_en), .i_angle(i_angles.roll_deg),
        .o_sin(sr), .o_cos(cr)
    );

    // First products: yaw times roll.
    logic signed [31:0] r_cycr, r_sysr, r_sycr, r_cysr, r_sp, r_cp;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_cycr <= mul_q30(cy, cr);
            r_sysr <= mul_q30(sy, sr);
            r_sycr <= mul_q30(sy, cr);
            r_cysr <= mul_q30(cy, sr);
            r_sp   <= sp;
            r_cp   <= cp;
        end
    end

    // Second products: pitch times the yaw-roll terms.
    logic signed [31:0] r_p_spcycr, r_p_cpsysr, r_p_cpsycr, r_p_spcysr;
    logic signed [31:0] r_p_cpcysr, r_p_spsycr, r_p_cpcycr, r_p_spsysr;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p_spcycr <= mul_q30(r_sp, r_cycr);
            r_p_cpsysr <= mul_q30(r_cp, r_sysr);
            r_p_cpsycr <= mul_q30(r_cp, r_sycr);
            r_p_spcysr <= mul_q30(r_sp, r_cysr);
            r_p_cpcysr <= mul_q30(r_cp, r_cysr);
            r_p_spsycr <= mul_q30(r_sp, r_sycr);
            r_p_cpcycr <= mul_q30(r_cp, r_cycr);
            r_p_spsysr <= mul_q30(r_sp, r_sysr);
        end
    end

    // Output register: sums and differences, clamped to unit range.
    logic signed [31:0] r_qx, r_qy, r_qz, r_qw;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_qx <= sat_q30(33'(r_p_spcycr) - 33'(r_p_cpsysr));
            r_qy <= sat_q30(33'(r_p_cpsycr) + 33'(r_p_spcysr));
            r_qz <= sat_q30(33'(r_p_cpcysr) - 33'(r_p_spsycr));
            r_qw <= sat_q30(33'(r_p_cpcycr) + 33'(r_p_spsysr));
        end
    end

    assign o_quat.valid  = r_vld[LAT-1];
    assign o_quat.quat_x = r_qx;
    assign o_quat.quat_y = r_qy;
    assign o_quat.quat_z = r_qz;
    assign o_quat.quat_w = r_qw;

`ifndef SYNTH
    // No word leaves right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_quat.valid)
        else $error("output valid after reset");

    // A held output freezes the valid bits of every stage.
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    // Every delivered component stays within unit range.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> (r_qx <= ONE_Q30 && r_qx >= -ONE_Q30 &&
                          r_qy <= ONE_Q30 && r_qy >= -ONE_Q30 &&
                          r_qz <= ONE_Q30 && r_qz >= -ONE_Q30 &&
                          r_qw <= ONE_Q30 && r_qw >= -ONE_Q30))
        else $error("quaternion component out of range");
`endif

endmodule
`default_nettype wire

// File: sim/e2q_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// Euler-to-quaternion checker
// Watches the angle and quaternion channels, computes the expected quaternion
// for every accepted angle word and compares each quaternion word with it.
// ----------------------------------------------------------------------------
module e2q_checker #(
    parameter int unsigned CORDIC_ITERATIONS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    e2q_angle_if      i_angles,
    e2q_quat_if       i_quat,
    output int        o_mismatches,
    output int        o_pending
);
    import e2q_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } t_quat;

    t_quat quat_q[$];

    // Floor shift and rounded Q2.30 product on 64-bit values.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    // Sine and cosine of the half angle carried by one raw input word.
    function automatic void half_angle_sincos(input logic signed [31:0] raw,
                                              output longint s, output longint c);
        longint r, mag, z, x, y, dx, dy;
        longint full_turn;
        bit     flip;
        int     steps;
        full_turn = 2 * 23592960;
        r = (longint'(raw) + 23592960) % full_turn;
        if (r < 0) r += full_turn;
        r -= 23592960;
        flip = 0;
        if (r > 11796480) begin
            r -= 23592960;
            flip = 1;
        end else if (r < -11796480) begin
            r += 23592960;
            flip = 1;
        end
        mag = (r < 0) ? -r : r;
        mag = (mag * longint'(32'hC90FDAA2) + 11796480) / 23592960;
        z = (r < 0) ? -mag : mag;
        x = 652032874;
        y = 0;
        steps = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
        for (int i = 0; i < steps; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic logic signed [31:0] clamp_unit(longint v);
        if (v > 1073741824) v = 1073741824;
        if (v < -1073741824) v = -1073741824;
        return v[31:0];
    endfunction

    function automatic t_quat angles_to_quat(logic signed [31:0] p, logic signed [31:0] yw,
                                             logic signed [31:0] rl);
        longint sp, cp, sy, cy, sr, cr, cycr, sysr, sycr, cysr;
        t_quat q;
        half_angle_sincos(p, sp, cp);
        half_angle_sincos(yw, sy, cy);
        half_angle_sincos(rl, sr, cr);
        cycr = qmul(cy, cr);
        sysr = qmul(sy, sr);
        sycr = qmul(sy, cr);
        cysr = qmul(cy, sr);
        q.x = clamp_unit(qmul(sp, cycr) - qmul(cp, sysr));
        q.y = clamp_unit(qmul(cp, sycr) + qmul(sp, cysr));
        q.z = clamp_unit(qmul(cp, cysr) - qmul(sp, sycr));
        q.w = clamp_unit(qmul(cp, cycr) + qmul(sp, sysr));
        return q;
    endfunction

    task automatic check_field(string name, logic signed [31:0] exp_v,
                               logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            o_mismatches++;
        end
    endtask

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // Predict on every accepted angle word, compare on every quaternion word.
    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n) begin
            if (i_angles.valid && i_angles.ready) begin
                quat_q.push_back(angles_to_quat(i_angles.pitch_deg, i_angles.yaw_deg,
                                                i_angles.roll_deg));
            end
            if (i_quat.valid && i_quat.ready) begin
                if (quat_q.size() == 0) begin
                    $display("%0t: unexpected quaternion word x=%0d", $time, i_quat.quat_x);
                    o_mismatches++;
                end else begin
                    exp_q = quat_q.pop_front();
                    check_field("quat_x", exp_q.x, i_quat.quat_x);
                    check_field("quat_y", exp_q.y, i_quat.quat_y);
                    check_field("quat_z", exp_q.z, i_quat.quat_z);
                    check_field("quat_w", exp_q.w, i_quat.quat_w);
                end
            end
        end
        o_pending = quat_q.size();
    end

endmodule
`default_nettype wire

// File: sim/euler_to_quaternion_test.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// Euler-to-quaternion testbench
// Drives directed and random angle words with random gaps and output stalls,
// including one long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module euler_to_quaternion_test;
    localparam int unsigned ITERS = 24;
    localparam int          NUM_RANDOM = 700;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    bit   calm;
    bit   hold_off;

    e2q_angle_if angles();
    e2q_quat_if  quat();

    euler_to_quaternion #(.CORDIC_ITERATIONS(ITERS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_angles(angles), .o_quat(quat)
    );

    e2q_checker #(.CORDIC_ITERATIONS(ITERS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_angles(angles), .i_quat(quat),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Random angle: mostly full-range, sometimes near the fold and wrap points or near zero.
    function automatic logic [31:0] pick_angle();
        int unsigned k;
        k = $urandom_range(9);
        if (k < 6) return $urandom;
        if (k < 8) return 32'(11796480 * $signed($urandom_range(8)) - 47185920)
                          + 32'($signed($urandom_range(8)) - 4);
        return 32'($signed($urandom_range(200000)) - 100000);
    endfunction

    // Offer one angle word and wait until it is taken.
    task automatic send_angles(logic [31:0] p, logic [31:0] y, logic [31:0] r);
        while (!calm && $urandom_range(99) < 21) begin
            angles.valid <= 1'b0;
            @(posedge i_clk);
        end
        angles.valid     <= 1'b1;
        angles.pitch_deg <= p;
        angles.yaw_deg   <= y;
        angles.roll_deg  <= r;
        do @(posedge i_clk); while (!angles.ready);
    endtask

    // Output side: random stalls, a calm stretch and one long hold-off.
    initial begin
        quat.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                quat.ready <= 1'b0;
                repeat (150) @(posedge i_clk);
                hold_off = 0;
            end
            quat.ready <= calm || ($urandom_range(99) >= 21);
            @(posedge i_clk);
        end
    end

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [31:0] edge_vals [10];
        int          waited;
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'd23592960,
                      -32'sd23592960, 32'd11796480, 32'd11796481, -32'sd11796481,
                      32'd47185920};
        angles.valid = 0;
        angles.pitch_deg = 0;
        angles.yaw_deg = 0;
        angles.roll_deg = 0;
        calm = 0;
        hold_off = 0;
        i_rst_n = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, wrap points and the fold boundaries.
        foreach (edge_vals[i]) send_angles(edge_vals[i], edge_vals[9 - i], edge_vals[(i + 3) % 10]);
        send_angles(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_angles(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_angles(32'd11796480, 32'd11796480, 32'd11796480);
        send_angles(32'd5898240, 32'd5898240, 32'd5898240);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm = (n >= 200 && n < 300);
            if (n == 400) hold_off = 1;
            send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        angles.valid <= 1'b0;
        calm = 0;

        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (ITERS + 20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
